>>> rtl/tgrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgrc_pkg
// Shared constants, widths and types of the tile grid ray caster.
// ----------------------------------------------------------------------------
package tgrc_pkg;

    localparam int MAP_SIZE  = 1024;
    localparam int FRAC_BITS = 16;
    localparam int MAP_W     = $clog2(MAP_SIZE);

    // Port field widths.
    localparam int TILE_IN_W = 10;
    localparam int COORD_W   = 26;
    localparam int DIR_W     = 18;
    localparam int DIST_W    = 27;
    localparam int HPOS_W    = 28;
    localparam int CODE_W    = 3;

    // Ray position accumulator and tile coordinates.
    localparam int POS_W  = COORD_W + 4;
    localparam int CELL_W = POS_W - FRAC_BITS;
    localparam int TC_W   = CELL_W + 1;

    // Slab time division.
    localparam int NUM_W    = TC_W + FRAC_BITS + 3;
    localparam int DVD_W    = NUM_W + FRAC_BITS;
    localparam int CNT_W    = $clog2(DVD_W + 1);
    localparam int T_SAT_SH = 40;
    localparam int T_W      = T_SAT_SH + 2;

    // March step counter and loop limit.
    localparam int STEP_W = DIST_W - FRAC_BITS + 1;
    localparam int LIM_W  = STEP_W + FRAC_BITS;
    localparam int STOP_W = T_W - FRAC_BITS;

    // Hit point multiply split.
    localparam int SPLIT = 24;
    localparam int MLO_W = DIR_W + SPLIT + 1;
    localparam int MHI_W = DIR_W + (T_W - 1 - SPLIT) + 1;
    localparam int SUM_W = DIR_W + T_W + 1;
    localparam int SX_W  = SUM_W - FRAC_BITS;
    localparam int HX_W  = SX_W + 1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [CODE_W-1:0] NRM_NONE = 3'd0;
    localparam logic [CODE_W-1:0] NRM_NX   = 3'd1;
    localparam logic [CODE_W-1:0] NRM_PX   = 3'd2;
    localparam logic [CODE_W-1:0] NRM_PY   = 3'd3;
    localparam logic [CODE_W-1:0] NRM_NY   = 3'd4;

    typedef struct packed {
        logic             valid;
        logic             wr;
        logic [MAP_W-1:0] row;
        logic [MAP_W-1:0] col;
        logic             solid;
    } t_map_req;

    typedef struct packed {
        logic ready;
        logic rd_bit;
    } t_map_rsp;

    // Neighbor order: center, +x, -x, +y, -y.
    function automatic logic signed [1:0] nbr_dx(input logic [2:0] k);
        logic signed [1:0] v;
        case (k)
            3'd1:    v = 2'sd1;
            3'd2:    v = -2'sd1;
            default: v = 2'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] nbr_dy(input logic [2:0] k);
        logic signed [1:0] v;
        case (k)
            3'd3:    v = 2'sd1;
            3'd4:    v = -2'sd1;
            default: v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/tgrc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgrc_if
// Command and result channels of the tile grid ray caster.
// ----------------------------------------------------------------------------
interface tgrc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [tgrc_pkg::TILE_IN_W-1:0]      tile_x;
    logic [tgrc_pkg::TILE_IN_W-1:0]      tile_y;
    logic                                solid;
    logic [tgrc_pkg::COORD_W-1:0]        origin_x;
    logic [tgrc_pkg::COORD_W-1:0]        origin_y;
    logic signed [tgrc_pkg::DIR_W-1:0]   dir_x;
    logic signed [tgrc_pkg::DIR_W-1:0]   dir_y;
    logic [tgrc_pkg::DIST_W-1:0]         ray_len;

    modport source(output valid, command, tile_x, tile_y, solid, origin_x, origin_y,
                   dir_x, dir_y, ray_len, input ready);
    modport sink(input valid, command, tile_x, tile_y, solid, origin_x, origin_y,
                 dir_x, dir_y, ray_len, output ready);
endinterface

interface tgrc_res_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [tgrc_pkg::CODE_W-1:0]         normal_code;
    logic [tgrc_pkg::DIST_W-1:0]         distance;
    logic signed [tgrc_pkg::HPOS_W-1:0]  hit_x;
    logic signed [tgrc_pkg::HPOS_W-1:0]  hit_y;

    modport source(output valid, hit, normal_code, distance, hit_x, hit_y, input ready);
    modport sink(input valid, hit, normal_code, distance, hit_x, hit_y, output ready);
endinterface
`default_nettype wire

>>> rtl/tgrc_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgrc_map
// Solid-tile map: one row per memory word, read-modify-write tile updates
// and a row-by-row clearing pass after reset.
// ----------------------------------------------------------------------------
module tgrc_map
    import tgrc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_map_req i_req,
    output t_map_rsp      o_rsp
);

    logic [MAP_SIZE-1:0] r_mem [MAP_SIZE];
    logic [MAP_SIZE-1:0] r_q;
    logic [MAP_W-1:0]    r_col;
    logic [MAP_W-1:0]    r_wr_row;
    logic                r_wr_bit;
    logic                r_wr_pend;
    logic                r_clr_busy;
    logic [MAP_W-1:0]    r_clr_row;
    logic [MAP_SIZE-1:0] wr_data;

    always_comb begin
        wr_data        = r_q;
        wr_data[r_col] = r_wr_bit;
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_row] <= '0;
        end else if (r_wr_pend) begin
            r_mem[r_wr_row] <= wr_data;
        end
        if (i_req.valid) begin
            r_q      <= r_mem[i_req.row];
            r_col    <= i_req.col;
            r_wr_row <= i_req.row;
            r_wr_bit <= i_req.solid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else begin
            r_wr_pend <= i_req.valid && i_req.wr;
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == MAP_W'(MAP_SIZE - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.ready  = !r_clr_busy;
    assign o_rsp.rd_bit = r_q[r_col];

endmodule
`default_nettype wire

>>> rtl/tgrc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tgrc_div
// Bit-serial floor division of a slab numerator (scaled by one tile) by a
// direction component, saturated to +-2^40.
// ----------------------------------------------------------------------------
module tgrc_div
    import tgrc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic signed [DIR_W-1:0] i_den,
    output logic                         o_done,
    output logic signed [T_W-1:0]        o_quo
);

    localparam int QX_W = DVD_W + 2;
    localparam logic signed [QX_W-1:0] SAT_HI = QX_W'(1) <<< T_SAT_SH;
    localparam logic signed [QX_W-1:0] SAT_LO = -SAT_HI;

    logic                    r_busy;
    logic                    r_fin;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [DVD_W-1:0]        r_dvd;
    logic [DIR_W-1:0]        r_rem;
    logic [DIR_W-1:0]        r_dmag;
    logic                    r_neg;
    logic signed [T_W-1:0]   r_quo;

    logic [NUM_W-1:0]        num_mag;
    logic [DIR_W-1:0]        den_mag;
    logic [DIR_W:0]          trial;
    logic [DIR_W:0]          diff;
    logic                    ge;
    logic [DIR_W-1:0]        rem_n;
    logic signed [QX_W-1:0]  mag;
    logic signed [QX_W-1:0]  val;
    logic signed [T_W-1:0]   sat_val;

    always_comb begin
        num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        den_mag = i_den[DIR_W-1] ? DIR_W'(-i_den) : DIR_W'(i_den);
        trial   = {r_rem, r_dvd[DVD_W-1]};
        diff    = trial - {1'b0, r_dmag};
        ge      = trial >= {1'b0, r_dmag};
        rem_n   = ge ? diff[DIR_W-1:0] : trial[DIR_W-1:0];
        // Floor rounding: a negative quotient with a remainder steps down by one.
        mag     = QX_W'(r_dvd) + QX_W'(r_neg && (r_rem != '0));
        val     = r_neg ? -mag : mag;
        if (val > SAT_HI) begin
            sat_val = T_W'(SAT_HI);
        end else if (val < SAT_LO) begin
            sat_val = T_W'(SAT_LO);
        end else begin
            sat_val = T_W'(val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {num_mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_dmag <= den_mag;
            r_neg  <= i_num[NUM_W-1] ^ i_den[DIR_W-1];
            if (i_den == '0) begin
                // Saturated reciprocal for a zero direction component.
                if (i_num == '0) begin
                    r_quo <= '0;
                end else if (i_num[NUM_W-1]) begin
                    r_quo <= T_W'(SAT_LO);
                end else begin
                    r_quo <= T_W'(SAT_HI);
                end
            end
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            r_rem <= rem_n;
        end else if (r_fin) begin
            r_quo <= sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(DVD_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

>>> rtl/tile_grid_ray_cast.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tile_grid_ray_cast
// Ray caster over a square map of solid-tile bits with slab ray-box tests.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per transaction. A write command sets or clears
//   one map tile and produces no result; it reads the tile's row from the map
//   memory and writes it back. A cast command marches the ray one unit step at
//   a time and produces one transaction on o_res with hit flag, face normal,
//   distance and hit point. Each step checks its five tiles in turn. Every
//   solid tile also costs four serial divisions (a zero direction component
//   skips the serial pass and saturates), and a hit then forms the hit point
//   in the states S_HM1, S_HM2 and S_HM3.
//   After reset the map memory is cleared one row per cycle, and i_cmd.ready
//   stays low until that pass is done.
//   The result sits in an output register: a stalled receiver does not block
//   further write commands, but a finished cast waits there until the
//   previous result has been taken.
// ----------------------------------------------------------------------------
module tile_grid_ray_cast
    import tgrc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tgrc_cmd_if.sink     i_cmd,
    tgrc_res_if.source   o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WR_RD = 4'd1;
    localparam logic [3:0] S_WR_WB = 4'd2;
    localparam logic [3:0] S_STEP  = 4'd3;
    localparam logic [3:0] S_NBR   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_EVAL  = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_HM1   = 4'd10;
    localparam logic [3:0] S_HM2   = 4'd11;
    localparam logic [3:0] S_HM3   = 4'd12;
    localparam logic [3:0] S_MISS  = 4'd13;

    localparam logic signed [HX_W-1:0] HPOS_MAX = HX_W'((1 <<< (HPOS_W - 1)) - 1);
    localparam logic signed [HX_W-1:0] HPOS_MIN = -HX_W'(1 <<< (HPOS_W - 1));
    localparam logic [T_W-1:0] DIST_MAX = T_W'((1 <<< DIST_W) - 1);

    logic [3:0]               r_state;
    logic [COORD_W-1:0]       r_ox, r_oy;
    logic signed [DIR_W-1:0]  r_dx, r_dy;
    logic [DIST_W-1:0]        r_maxlen;
    logic signed [POS_W-1:0]  r_px, r_py;
    logic [STEP_W-1:0]        r_i;
    logic [2:0]               r_k;
    logic [1:0]               r_j;
    logic signed [TC_W-1:0]   r_tx, r_ty;
    logic signed [T_W-1:0]    r_t [4];
    logic                     r_have;
    logic signed [T_W-1:0]    r_near;
    logic [CODE_W-1:0]        r_code;
    logic signed [MLO_W-1:0]  r_mlo_x, r_mlo_y;
    logic signed [MHI_W-1:0]  r_mhi_x, r_mhi_y;
    logic signed [SX_W-1:0]   r_sx, r_sy;

    logic                     r_out_valid;
    logic                     r_out_hit;
    logic [CODE_W-1:0]        r_out_code;
    logic [DIST_W-1:0]        r_out_dist;
    logic signed [HPOS_W-1:0] r_out_hx, r_out_hy;

    t_map_req                 map_req;
    t_map_rsp                 map_rsp;
    logic                     div_start;
    logic                     div_done;
    logic signed [T_W-1:0]    div_quo;
    logic signed [NUM_W-1:0]  div_num;
    logic signed [DIR_W-1:0]  div_den;

    logic                     out_free;
    logic                     cmd_fire;
    logic [LIM_W-1:0]         step_fx;
    logic [LIM_W-1:0]         limit;
    logic signed [TC_W-1:0]   tx_c, ty_c;
    logic                     outside;
    logic signed [NUM_W-1:0]  x0, y0;
    logic signed [T_W-1:0]    ax, bx, ay, by, tmin, tmax;
    logic [CODE_W-1:0]        code_c;
    logic                     take;
    logic                     stop;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [HX_W-1:0]   hx, hy;
    logic [15:0]              wr_tx, wr_ty;

    function automatic logic signed [HPOS_W-1:0] clamp_pos(input logic signed [HX_W-1:0] v);
        logic signed [HPOS_W-1:0] r;
        if (v > HPOS_MAX) begin
            r = HPOS_W'(HPOS_MAX);
        end else if (v < HPOS_MIN) begin
            r = HPOS_W'(HPOS_MIN);
        end else begin
            r = HPOS_W'(v);
        end
        return r;
    endfunction

    tgrc_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rsp   (map_rsp)
    );

    tgrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        out_free  = !r_out_valid || o_res.ready;
        cmd_fire  = i_cmd.valid && i_cmd.ready;
        wr_tx     = 16'(i_cmd.tile_x);
        wr_ty     = 16'(i_cmd.tile_y);
        step_fx   = {r_i, {FRAC_BITS{1'b0}}};
        limit     = LIM_W'(r_maxlen) + LIM_W'(3 << FRAC_BITS);

        tx_c    = TC_W'($signed(r_px[POS_W-1:FRAC_BITS])) + TC_W'(nbr_dx(r_k));
        ty_c    = TC_W'($signed(r_py[POS_W-1:FRAC_BITS])) + TC_W'(nbr_dy(r_k));
        // Tiles beyond the map edges count as solid.
        outside = tx_c[TC_W-1] || ty_c[TC_W-1] ||
                  (tx_c >= TC_W'(MAP_SIZE)) || (ty_c >= TC_W'(MAP_SIZE));

        map_req = '0;
        if (r_state == S_WR_RD) begin
            map_req.valid = 1'b1;
            map_req.wr    = 1'b1;
            map_req.row   = r_ty[MAP_W-1:0];
            map_req.col   = r_tx[MAP_W-1:0];
            map_req.solid = r_code[0];
        end else if (r_state == S_NBR && !outside) begin
            map_req.valid = 1'b1;
            map_req.row   = ty_c[MAP_W-1:0];
            map_req.col   = tx_c[MAP_W-1:0];
        end

        x0 = NUM_W'(r_tx) <<< FRAC_BITS;
        y0 = NUM_W'(r_ty) <<< FRAC_BITS;
        case (r_j)
            2'd0:    div_num = x0 - NUM_W'(r_ox);
            2'd1:    div_num = x0 + NUM_W'(1 << FRAC_BITS) - NUM_W'(r_ox);
            2'd2:    div_num = y0 + NUM_W'(1 << FRAC_BITS) - NUM_W'(r_oy);
            default: div_num = y0 - NUM_W'(r_oy);
        endcase
        div_den   = r_j[1] ? r_dy : r_dx;
        div_start = (r_state == S_DIV);

        ax   = (r_t[0] < r_t[1]) ? r_t[0] : r_t[1];
        bx   = (r_t[0] < r_t[1]) ? r_t[1] : r_t[0];
        ay   = (r_t[2] < r_t[3]) ? r_t[2] : r_t[3];
        by   = (r_t[2] < r_t[3]) ? r_t[3] : r_t[2];
        tmin = (ax > ay) ? ax : ay;
        tmax = (bx < by) ? bx : by;
        if (tmin == r_t[0]) begin
            code_c = NRM_NX;
        end else if (tmin == r_t[1]) begin
            code_c = NRM_PX;
        end else if (tmin == r_t[2]) begin
            code_c = NRM_PY;
        end else if (tmin == r_t[3]) begin
            code_c = NRM_NY;
        end else begin
            code_c = NRM_NONE;
        end
        take = !tmax[T_W-1] && (tmin <= tmax) && !tmin[T_W-1] &&
               (!r_have || (tmin < r_near));

        stop = r_have && (STOP_W'(r_i) >
               (STOP_W'(r_near[T_W-2:FRAC_BITS]) + STOP_W'(2)));

        sum_x = (SUM_W'(r_mhi_x) <<< SPLIT) + SUM_W'(r_mlo_x);
        sum_y = (SUM_W'(r_mhi_y) <<< SPLIT) + SUM_W'(r_mlo_y);
        hx    = HX_W'(r_sx) + HX_W'(r_ox);
        hy    = HX_W'(r_sy) + HX_W'(r_oy);
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    r_tx     <= TC_W'(wr_tx);
                    r_ty     <= TC_W'(wr_ty);
                    r_code   <= CODE_W'(i_cmd.solid);
                    r_ox     <= i_cmd.origin_x;
                    r_oy     <= i_cmd.origin_y;
                    r_dx     <= i_cmd.dir_x;
                    r_dy     <= i_cmd.dir_y;
                    r_maxlen <= i_cmd.ray_len;
                    r_px     <= POS_W'(i_cmd.origin_x);
                    r_py     <= POS_W'(i_cmd.origin_y);
                    r_i      <= '0;
                    r_near   <= '0;
                end
            end
            S_STEP: begin
                r_k <= '0;
            end
            S_NBR: begin
                r_tx <= tx_c;
                r_ty <= ty_c;
                r_j  <= '0;
            end
            S_DIVW: begin
                if (div_done) begin
                    r_t[r_j] <= div_quo;
                    r_j      <= r_j + 1'b1;
                end
            end
            S_EVAL: begin
                if (take) begin
                    r_near <= tmin;
                    r_code <= code_c;
                end
            end
            S_NEXT: begin
                if (r_k != 3'd4) begin
                    r_k <= r_k + 1'b1;
                end else if (!stop) begin
                    r_i  <= r_i + 1'b1;
                    r_px <= r_px + POS_W'(r_dx);
                    r_py <= r_py + POS_W'(r_dy);
                end
            end
            S_HM1: begin
                r_mlo_x <= r_dx * $signed({1'b0, r_near[SPLIT-1:0]});
                r_mlo_y <= r_dy * $signed({1'b0, r_near[SPLIT-1:0]});
                r_mhi_x <= r_dx * $signed({1'b0, r_near[T_W-2:SPLIT]});
                r_mhi_y <= r_dy * $signed({1'b0, r_near[T_W-2:SPLIT]});
            end
            S_HM2: begin
                r_sx <= sum_x[SUM_W-1:FRAC_BITS];
                r_sy <= sum_y[SUM_W-1:FRAC_BITS];
            end
            default: begin
            end
        endcase

        if (r_state == S_HM3 && out_free) begin
            r_out_hit  <= 1'b1;
            r_out_code <= r_code;
            r_out_dist <= (r_near > $signed(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                       : r_near[DIST_W-1:0];
            r_out_hx   <= clamp_pos(hx);
            r_out_hy   <= clamp_pos(hy);
        end else if (r_state == S_MISS && out_free) begin
            r_out_hit  <= 1'b0;
            r_out_code <= NRM_NONE;
            r_out_dist <= r_maxlen;
            r_out_hx   <= '0;
            r_out_hy   <= '0;
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_have <= 1'b0;
                        if (i_cmd.command == CMD_CAST) begin
                            r_state <= S_STEP;
                        end else if (wr_tx < 16'(MAP_SIZE) && wr_ty < 16'(MAP_SIZE)) begin
                            r_state <= S_WR_RD;
                        end
                    end
                end
                S_WR_RD: r_state <= S_WR_WB;
                S_WR_WB: r_state <= S_IDLE;
                S_STEP: begin
                    r_state <= (step_fx < limit) ? S_NBR : S_MISS;
                end
                S_NBR: begin
                    r_state <= outside ? S_DIV : S_RD;
                end
                S_RD: begin
                    r_state <= map_rsp.rd_bit ? S_DIV : S_NEXT;
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= (r_j == 2'd3) ? S_EVAL : S_DIV;
                    end
                end
                S_EVAL: begin
                    if (take) begin
                        r_have <= 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_k != 3'd4) begin
                        r_state <= S_NBR;
                    end else begin
                        r_state <= stop ? S_HM1 : S_STEP;
                    end
                end
                S_HM1: r_state <= S_HM2;
                S_HM2: r_state <= S_HM3;
                S_HM3, S_MISS: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE) && map_rsp.ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.hit         = r_out_hit;
    assign o_res.normal_code = r_out_code;
    assign o_res.distance    = r_out_dist;
    assign o_res.hit_x       = r_out_hx;
    assign o_res.hit_y       = r_out_hy;

endmodule
`default_nettype wire

>>> sim/tile_grid_ray_cast_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_grid_ray_cast_tb
// Drives map writes and ray casts into the tile grid ray caster, predicts each
// cast result from a directed row or an independent fixed-point ray march over
// a local copy of the tile map, and compares every result field by field.
// ----------------------------------------------------------------------------
module tile_grid_ray_cast_tb;
    import tgrc_pkg::*;

    localparam longint ONE   = 64'sd1 <<< FRAC_BITS;
    localparam longint T_LIM = 64'sd1 <<< 40;

    typedef struct {
        logic        command;
        bit [9:0]    tile_x;
        bit [9:0]    tile_y;
        bit          solid;
        bit [25:0]   origin_x;
        bit [25:0]   origin_y;
        bit [17:0]   dir_x;
        bit [17:0]   dir_y;
        bit [26:0]   ray_len;
    } ray_cmd_t;

    typedef struct {
        bit          hit;
        bit [2:0]    normal_code;
        bit [26:0]   distance;
        bit [27:0]   hit_x;
        bit [27:0]   hit_y;
    } ray_res_t;

    typedef struct {
        ray_cmd_t    cmd;
        bit          known;
        ray_res_t    res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tgrc_cmd_if cmd_if ();
    tgrc_res_if res_if ();

    tile_grid_ray_cast i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bit [MAP_SIZE-1:0] tile_map [MAP_SIZE];
    ray_res_t          pending_hits [$];
    stim_row_t         directed_rows [$];
    int                mismatch_count = 0;

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic longint slab_time(longint num, longint d);
        longint n, q;
        if (d == 0)
            return (num > 0) ? T_LIM : ((num < 0) ? -T_LIM : 64'sd0);
        n = num * ONE;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q--;
        return (q < -T_LIM) ? -T_LIM : ((q > T_LIM) ? T_LIM : q);
    endfunction

    function automatic bit tile_blocks(longint x, longint y);
        if (x < 0 || y < 0 || x >= MAP_SIZE || y >= MAP_SIZE)
            return 1'b1;
        return tile_map[y][x];
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic ray_res_t march_ray(ray_cmd_t c);
        ray_res_t r;
        longint ox, oy, dx, dy, limit, nearest, cx, cy, tx, ty;
        longint t1, t2, t3, t4, ax, bx, ay, by, tmin, tmax;
        bit [2:0] near_code, code;
        bit have;
        ox = longint'(c.origin_x);
        oy = longint'(c.origin_y);
        dx = longint'($signed(c.dir_x));
        dy = longint'($signed(c.dir_y));
        limit = longint'(c.ray_len) + 3 * ONE;
        have = 1'b0;
        nearest = 0;
        near_code = NRM_NONE;
        for (longint i = 0; i * ONE < limit; i++) begin
            cx = (ox + dx * i) >>> FRAC_BITS;
            cy = (oy + dy * i) >>> FRAC_BITS;
            for (int k = 0; k < 5; k++) begin
                tx = cx + ((k == 1) ? 1 : ((k == 2) ? -1 : 0));
                ty = cy + ((k == 3) ? 1 : ((k == 4) ? -1 : 0));
                if (!tile_blocks(tx, ty))
                    continue;
                t1 = slab_time(tx * ONE - ox, dx);
                t2 = slab_time(tx * ONE + ONE - ox, dx);
                t3 = slab_time(ty * ONE + ONE - oy, dy);
                t4 = slab_time(ty * ONE - oy, dy);
                ax = (t1 < t2) ? t1 : t2;
                bx = (t1 < t2) ? t2 : t1;
                ay = (t3 < t4) ? t3 : t4;
                by = (t3 < t4) ? t4 : t3;
                tmin = (ax > ay) ? ax : ay;
                tmax = (bx < by) ? bx : by;
                if (tmax < 0 || tmin > tmax || tmin < 0)
                    continue;
                if (tmin == t1) code = NRM_NX;
                else if (tmin == t2) code = NRM_PX;
                else if (tmin == t3) code = NRM_PY;
                else if (tmin == t4) code = NRM_NY;
                else code = NRM_NONE;
                if (!have || tmin < nearest) begin
                    have = 1'b1;
                    nearest = tmin;
                    near_code = code;
                end
            end
            if (have && i > (nearest >>> FRAC_BITS) + 2) begin
                r.hit = 1'b1;
                r.normal_code = near_code;
                r.distance = 27'(clamp(nearest, 0, (64'sd1 <<< 27) - 1));
                r.hit_x = 28'(clamp(ox + ((dx * nearest) >>> FRAC_BITS),
                                    -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1));
                r.hit_y = 28'(clamp(oy + ((dy * nearest) >>> FRAC_BITS),
                                    -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1));
                return r;
            end
        end
        r.hit = 1'b0;
        r.normal_code = NRM_NONE;
        r.distance = c.ray_len;
        r.hit_x = '0;
        r.hit_y = '0;
        return r;
    endfunction

    function automatic ray_cmd_t tile_write(int x, int y, bit s);
        ray_cmd_t c;
        c = '{default: '0};
        c.command = CMD_WRITE;
        c.tile_x = 10'(x);
        c.tile_y = 10'(y);
        c.solid = s;
        return c;
    endfunction

    function automatic ray_cmd_t ray_cast(bit [25:0] ox, bit [25:0] oy, int dx, int dy,
                                          bit [26:0] len);
        ray_cmd_t c;
        c = '{default: '0};
        c.command = CMD_CAST;
        c.origin_x = ox;
        c.origin_y = oy;
        c.dir_x = 18'(dx);
        c.dir_y = 18'(dy);
        c.ray_len = len;
        return c;
    endfunction

    function automatic void add_row(ray_cmd_t c, bit known = 0, ray_res_t r = '{default: '0});
        directed_rows.push_back('{cmd: c, known: known, res: r});
    endfunction

    function automatic void build_directed();
        bit [25:0] mid;
        mid = 26'(512) << FRAC_BITS | 26'h8000;
        // Empty map right after reset: a zero-length cast finds nothing.
        add_row(ray_cast(mid, mid, 65536, 0, 0), 1,
                '{hit: 0, normal_code: NRM_NONE, distance: 0, hit_x: 0, hit_y: 0});
        // Standing still at the map corner: the tile beyond the left edge is struck at once.
        add_row(ray_cast(0, 0, 0, 0, 27'(1) << FRAC_BITS), 1,
                '{hit: 1, normal_code: NRM_PX, distance: 0, hit_x: 0, hit_y: 0});
        // Longest ray, standing still in clear space: a miss at full length.
        add_row(ray_cast(mid, mid, 0, 0, '1), 1,
                '{hit: 0, normal_code: NRM_NONE, distance: '1, hit_x: 0, hit_y: 0});
        add_row(ray_cast('1, '1, 0, 0, 0));
        add_row(tile_write(0, 0, 1));
        add_row(tile_write(1023, 1023, 1));
        add_row(tile_write(1023, 0, 1));
        add_row(tile_write(1023, 0, 0));
        add_row(tile_write(516, 512, 1));
        add_row(tile_write(508, 512, 1));
        add_row(tile_write(512, 516, 1));
        add_row(tile_write(512, 508, 1));
        add_row(ray_cast(mid, mid, 65536, 0, 27'(8) << FRAC_BITS));
        add_row(ray_cast(mid, mid, -65536, 0, 27'(8) << FRAC_BITS));
        add_row(ray_cast(mid, mid, 0, 65536, 27'(8) << FRAC_BITS));
        add_row(ray_cast(mid, mid, 0, -65536, 27'(8) << FRAC_BITS));
        add_row(ray_cast(mid, mid, 46341, 46341, 27'(8) << FRAC_BITS));
        // Direction patterns outside the nominal unit range.
        add_row(ray_cast(mid, mid, 18'h1FFFF, 18'h20000, 27'(8) << FRAC_BITS));
        add_row(ray_cast(mid, mid, 18'h20000, 18'h1FFFF, 27'(8) << FRAC_BITS));
        add_row(ray_cast(26'(2) << FRAC_BITS, 26'(1021) << FRAC_BITS, -65536, 65536,
                         27'(6) << FRAC_BITS));
        add_row(tile_write(516, 512, 0));
        add_row(ray_cast(mid, mid, 65536, 0, 27'(8) << FRAC_BITS));
    endfunction

    function automatic ray_cmd_t random_item(int base_x, int base_y);
        ray_cmd_t c;
        int sel;
        if ($urandom_range(99) < 45)
            return tile_write(base_x + $urandom_range(15), base_y + $urandom_range(15),
                              $urandom_range(99) < 30);
        c = ray_cast({10'(base_x + $urandom_range(15)), 16'($urandom)},
                     {10'(base_y + $urandom_range(15)), 16'($urandom)}, 0, 0, 0);
        sel = $urandom_range(19);
        if (sel == 0) begin
            c.dir_x = 18'($urandom);
            c.dir_y = 18'($urandom);
        end else if (sel < 4) begin
            c.dir_x = 18'(($urandom_range(1) ? 65536 : -65536) * $urandom_range(1));
            c.dir_y = 18'(($urandom_range(1) ? 65536 : -65536) * $urandom_range(1));
        end else begin
            c.dir_x = 18'($urandom_range(131072) - 65536);
            c.dir_y = 18'($urandom_range(131072) - 65536);
        end
        c.ray_len = ($urandom_range(99) == 0) ? 27'($urandom)
                                              : 27'($urandom_range(8 << FRAC_BITS));
        return c;
    endfunction

    // Receiver stalls with a random duty of 0, 30, 70 or 95 percent that is redrawn periodically.
    int stall_pct = 0;
    int rx_cycle = 0;
    initial res_if.ready = 1'b0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) begin
            case ($urandom_range(4))
                0, 1:    stall_pct <= 0;
                2:       stall_pct <= 30;
                3:       stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
        end
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        ray_res_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_hits.pop_front();
                if (res_if.hit !== want.hit)
                    report_mismatch("hit", res_if.hit, want.hit);
                if (res_if.normal_code !== want.normal_code)
                    report_mismatch("normal_code", res_if.normal_code, want.normal_code);
                if (res_if.distance !== want.distance)
                    report_mismatch("distance", res_if.distance, want.distance);
                if (res_if.hit_x !== want.hit_x)
                    report_mismatch("hit_x", $signed(res_if.hit_x), $signed(want.hit_x));
                if (res_if.hit_y !== want.hit_y)
                    report_mismatch("hit_y", $signed(res_if.hit_y), $signed(want.hit_y));
            end
        end
    end

    task automatic send_item(stim_row_t row, inout int burst_left);
        if (burst_left == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= row.cmd.command;
        cmd_if.tile_x     <= row.cmd.tile_x;
        cmd_if.tile_y     <= row.cmd.tile_y;
        cmd_if.solid      <= row.cmd.solid;
        cmd_if.origin_x   <= row.cmd.origin_x;
        cmd_if.origin_y   <= row.cmd.origin_y;
        cmd_if.dir_x      <= row.cmd.dir_x;
        cmd_if.dir_y      <= row.cmd.dir_y;
        cmd_if.ray_len    <= row.cmd.ray_len;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        // The transaction was taken at this edge: update the map copy or predict.
        if (row.cmd.command == CMD_WRITE)
            tile_map[row.cmd.tile_y][row.cmd.tile_x] = row.cmd.solid;
        else
            pending_hits.push_back(row.known ? row.res : march_ray(row.cmd));
    endtask

    initial begin
        stim_row_t row;
        int burst_left;
        int base_x, base_y;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_WRITE;
        cmd_if.tile_x = '0;
        cmd_if.tile_y = '0;
        cmd_if.solid = 1'b0;
        cmd_if.origin_x = '0;
        cmd_if.origin_y = '0;
        cmd_if.dir_x = '0;
        cmd_if.dir_y = '0;
        cmd_if.ray_len = '0;
        foreach (tile_map[y])
            tile_map[y] = '0;
        build_directed();
        burst_left = 0;
        base_x = 504;
        base_y = 504;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[n])
            send_item(directed_rows[n], burst_left);
        for (int n = 0; n < 730; n++) begin
            // Move the working region now and then, edges of the map included.
            if (n % 60 == 0) begin
                case ($urandom_range(2))
                    0:       base_x = 0;
                    1:       base_x = 1008;
                    default: base_x = $urandom_range(16, 992);
                endcase
                case ($urandom_range(2))
                    0:       base_y = 0;
                    1:       base_y = 1008;
                    default: base_y = $urandom_range(16, 992);
                endcase
            end
            row = '{cmd: random_item(base_x, base_y), known: 0, res: '{default: '0}};
            send_item(row, burst_left);
        end
        cmd_if.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #500_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tgrc_pkg.sv
rtl/tgrc_if.sv
rtl/tgrc_map.sv
rtl/tgrc_div.sv
rtl/tile_grid_ray_cast.sv
sim/tile_grid_ray_cast_tb.sv
